[rtl/pct_pkg.sv]
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the pending count table
// Table size, beat layouts, opcodes and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OPCODE_W  = 2;
    localparam int VALUE_W   = 32;
    localparam int FOUND_W   = 1;
    localparam int S_TDATA_W = ((OPCODE_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FOUND_W + VALUE_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_MATCH = 2'd1,
        OP_POP   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the accepted beat, restart the scan
        logic step;    // issue one table read, advance the scan index
        logic finish;  // commit table update, load the output register
    } pct_cmd_t;

    // datapath -> controller
    typedef struct packed {
        opcode_t opcode;
        logic    scan_last;
        logic    out_free;
    } pct_status_t;

endpackage

`default_nettype wire

[rtl/pct_ram.sv]
// ----------------------------------------------------------------------------
// pct_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                 wr_data,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/pct_ctrl.sv]
// ----------------------------------------------------------------------------
// pct_ctrl: request sequencer of the pending count table
// Accepts one beat, walks the table for match/pop, then hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire pct_pkg::pct_status_t status,
    output pct_pkg::pct_cmd_t         cmd
);

    import pct_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    // match and pop walk the table first
                    if (status.opcode == OP_MATCH || status.opcode == OP_POP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            // last read data still in flight
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/pct_datapath.sv]
// ----------------------------------------------------------------------------
// pct_datapath: storage and compare path of the pending count table
// Count RAM, valid bits, ring pointer, scan compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pct_pkg::opcode_t     in_opcode,
    input  wire pct_pkg::value_t      in_value,
    input  wire pct_pkg::pct_cmd_t    cmd,
    output pct_pkg::pct_status_t      status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic                      out_found,
    output pct_pkg::value_t           out_result_value
);

    import pct_pkg::*;

    opcode_t          opcode_reg;
    value_t           value_reg;
    idx_t             scan_idx_reg;
    idx_t             cmp_idx_reg;
    logic             cmp_en_reg;
    logic             hit_reg;
    value_t           best_reg;
    idx_t             best_idx_reg;
    logic [DEPTH-1:0] valid_reg;
    idx_t             ptr_reg;
    logic             m_tvalid_reg;
    logic             found_reg;
    value_t           result_reg;

    value_t           rd_data;
    logic             ram_wr_en;
    logic             cand;
    logic             take;
    logic             found_next;
    value_t           result_next;

    assign ram_wr_en = cmd.finish && (opcode_reg == OP_WRITE);

    pct_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (value_reg),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    // candidate entry: match keeps the first equal one, pop keeps strictly smaller
    always_comb
    begin
        cand = cmp_en_reg && valid_reg[cmp_idx_reg];
        take = 1'b0;
        case (opcode_reg)
            OP_MATCH: take = cand && !hit_reg && (rd_data == value_reg);
            OP_POP:   take = cand && (!hit_reg || (rd_data < best_reg));
            default:  take = 1'b0;
        endcase
    end

    always_comb
    begin
        found_next  = 1'b0;
        result_next = value_reg;
        case (opcode_reg)
            OP_WRITE: found_next = 1'b1;
            OP_MATCH: found_next = hit_reg;
            OP_POP:
            begin
                found_next  = hit_reg;
                result_next = hit_reg ? best_reg : '0;
            end
            default:  found_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg <= in_opcode;
            value_reg  <= in_value;
        end
        cmp_idx_reg <= scan_idx_reg;
        if (take)
        begin
            best_reg     <= rd_data;
            best_idx_reg <= cmp_idx_reg;
        end
        if (cmd.finish)
        begin
            found_reg  <= found_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_en_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            valid_reg    <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.step;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (take)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                if (opcode_reg == OP_WRITE)
                begin
                    valid_reg[ptr_reg] <= 1'b1;
                    ptr_reg <= (ptr_reg == idx_t'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                end
                else if (hit_reg && (opcode_reg == OP_MATCH || opcode_reg == OP_POP))
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                end
            end
            if (cmd.finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // opcode of the beat on offer, so the controller can branch at accept
    assign status.opcode    = in_opcode;
    assign status.scan_last = (scan_idx_reg == idx_t'(DEPTH - 1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid         = m_tvalid_reg;
    assign out_found        = found_reg;
    assign out_result_value = result_reg;

endmodule

`default_nettype wire

[rtl/pending_count_table.sv]
// ----------------------------------------------------------------------------
// pending_count_table: ring of sample counts with match and pop-minimum
// A write stores a count at the ring pointer and goes from accept straight to
// the finish state. Match and pop-minimum walk all DEPTH entries through the
// single read port of the count RAM, one entry per cycle, then pass a drain
// state before finish. One request is in flight at a time; the next beat is
// accepted once the current result sits in the output register, which may
// still be waiting for m_tready. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_count_table (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata fields, low bit up: opcode[1:0], value[33:2], zero pad
    input  wire logic [pct_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata fields, low bit up: found[0], result_value[32:1], zero pad
    output logic      [pct_pkg::M_TDATA_W-1:0]   m_tdata
);

    import pct_pkg::*;

    pct_cmd_t    cmd;
    pct_status_t status;
    opcode_t     in_opcode;
    value_t      in_value;
    logic        out_found;
    value_t      out_result_value;

    assign in_opcode = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign in_value  = s_tdata[OPCODE_W +: VALUE_W];

    pct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pct_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_opcode        (in_opcode),
        .in_value         (in_value),
        .cmd              (cmd),
        .status           (status),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .out_found        (out_found),
        .out_result_value (out_result_value)
    );

    assign m_tdata = {{(M_TDATA_W - FOUND_W - VALUE_W){1'b0}}, out_result_value, out_found};

endmodule

`default_nettype wire

[rtl/pct_checker.sv]
// ----------------------------------------------------------------------------
// pct_checker: port-level checks of the pending count table
// Watches the two stream interfaces and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [pct_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [pct_pkg::M_TDATA_W-1:0]   m_tdata
);

    import pct_pkg::*;

    // one request at a time: ready drops right after a beat is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request is in flight");

    // a write with an empty output stage reports found and echoes its value
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid &&
        (s_tdata[OPCODE_W-1:0] == OP_WRITE)
        |-> ##2 (m_tvalid && m_tdata[0] &&
                 (m_tdata[VALUE_W:1] == $past(s_tdata[OPCODE_W +: VALUE_W], 2))))
        else $error("write result missing or wrong");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind pending_count_table pct_checker u_pct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
